[src/atrp_pkg.sv]
package atrp_pkg;

    localparam int N_STEPS  = 20;
    localparam int AW       = 26;
    localparam int FRAC_IN  = 16;
    localparam int OUT_SHIFT = 10;
    localparam int ROLL_W   = 15;
    localparam int PITCH_W  = 14;

    typedef logic signed [AW-1:0] t_angle;
    typedef logic signed [AW:0]   t_angle_w;

    typedef enum logic [1:0] {
        SP_NONE,
        SP_POS90,
        SP_NEG90,
        SP_ZERO
    } t_spec;

    localparam t_angle_w ANG_90    = 27'sd5898240;
    localparam t_angle   ANG_180   = 26'sd11796480;
    localparam t_angle_w ROUND_OFS = 27'sd512;
    localparam t_angle_w ROLL_LIM  = 27'sd11520;
    localparam t_angle_w PITCH_LIM = 27'sd5760;

    localparam t_angle ATAN_TAB [N_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117304,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
        26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
        26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7
    };

    function automatic t_angle_w f_round(input t_angle a, input t_spec s);
        t_angle_w v;
        case (s)
            SP_POS90: v = ANG_90;
            SP_NEG90: v = -ANG_90;
            SP_ZERO:  v = '0;
            default:  v = {a[AW-1], a};
        endcase
        f_round = (v + ROUND_OFS) >>> OUT_SHIFT;
    endfunction

    function automatic t_angle_w f_sat(input t_angle_w r, input t_angle_w lim);
        if (r > lim) begin
            f_sat = lim;
        end else if (r < -lim) begin
            f_sat = -lim;
        end else begin
            f_sat = r;
        end
    endfunction

endpackage

[src/atrp_if.sv]
interface atrp_in_if #(parameter int SAMPLE_BITS = 12) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface atrp_out_if ();
    import atrp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ROLL_W-1:0]  roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;

    modport source (output valid, output roll_angle, output pitch_angle, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

[src/atrp_sqrt_cell.sv]
module atrp_sqrt_cell #(
    parameter int MW = 24,
    parameter int R  = 28,
    parameter int SW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_valid,
    input  logic [MW-1:0] i_rad,
    input  logic [R+2:0]  i_rem,
    input  logic [R-1:0]  i_root,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [MW-1:0] o_rad,
    output logic [R+2:0]  o_rem,
    output logic [R-1:0]  o_root,
    output logic [SW-1:0] o_side
);
    logic [R+2:0]  w_cur;
    logic [R+2:0]  w_trial;
    logic [R+2:0]  n_rem;
    logic [R-1:0]  n_root;
    logic          r_valid;
    logic [MW-1:0] r_rad;
    logic [R+2:0]  r_rem;
    logic [R-1:0]  r_root;
    logic [SW-1:0] r_side;

    assign w_cur   = {i_rem[R:0], i_rad[MW-1 -: 2]};
    assign w_trial = {1'b0, i_root, 2'b01};

    always_comb begin
        if (w_cur >= w_trial) begin
            n_rem  = w_cur - w_trial;
            n_root = {i_root[R-2:0], 1'b1};
        end else begin
            n_rem  = w_cur;
            n_root = {i_root[R-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rad  <= {i_rad[MW-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;
endmodule

[src/atrp_cordic_cell.sv]
module atrp_cordic_cell #(
    parameter int W    = 30,
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic                  i_valid,
    input  logic signed [W-1:0]   i_x,
    input  logic signed [W-1:0]   i_y,
    input  atrp_pkg::t_angle      i_acc,
    input  atrp_pkg::t_spec       i_spec,
    output logic                  o_valid,
    output logic signed [W-1:0]   o_x,
    output logic signed [W-1:0]   o_y,
    output atrp_pkg::t_angle      o_acc,
    output atrp_pkg::t_spec       o_spec
);
    import atrp_pkg::*;

    logic signed [W-1:0] w_dx;
    logic signed [W-1:0] w_dy;
    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    t_angle              n_acc;
    logic                r_valid;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    t_angle              r_acc;
    t_spec               r_spec;

    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    always_comb begin
        if (!i_y[W-1]) begin
            n_x   = i_x + w_dx;
            n_y   = i_y - w_dy;
            n_acc = i_acc + ATAN_TAB[STEP];
        end else begin
            n_x   = i_x - w_dx;
            n_y   = i_y + w_dy;
            n_acc = i_acc - ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_spec <= i_spec;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_spec  = r_spec;
endmodule

[src/accel_tilt_roll_pitch.sv]
// Datapath: an accepted sample passes through the input register, the squaring stage,
// SAMPLE_BITS + 16 square-root cells, 20 CORDIC cells and the output register.
// Throughput: one sample per cycle; the whole chain stalls only while a result waits.
// Reset: synchronous, active low; clears all valid bits, data registers keep contents.
module accel_tilt_roll_pitch #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atrp_in_if.sink     i_in,
    atrp_out_if.source  o_out
);
    import atrp_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int MW = 2 * SB;
    localparam int R  = SB + 16;
    localparam int W  = SB + 18;
    localparam int D  = R + 1;

    logic w_ce;

    logic                 r_v0;
    logic signed [SB-1:0] r_x;
    logic signed [SB-1:0] r_y;
    logic signed [SB-1:0] r_z;

    logic                 r_v1;
    logic [MW-1:0]        r_yy;
    logic [MW-1:0]        r_zz;
    logic signed [SB-1:0] r_x1;

    logic signed [W-1:0] w_y0;
    logic signed [W-1:0] w_z0;
    t_angle              w_base;
    t_spec               w_rspec;

    logic                 rc_v    [N_STEPS+1];
    logic signed [W-1:0]  rc_x    [N_STEPS+1];
    logic signed [W-1:0]  rc_y    [N_STEPS+1];
    t_angle               rc_acc  [N_STEPS+1];
    t_spec                rc_spec [N_STEPS+1];

    logic                 sq_v    [R+1];
    logic [MW-1:0]        sq_rad  [R+1];
    logic [R+2:0]         sq_rem  [R+1];
    logic [R-1:0]         sq_root [R+1];
    logic [SB-1:0]        sq_side [R+1];

    logic                 pc_v    [N_STEPS+1];
    logic signed [W-1:0]  pc_x    [N_STEPS+1];
    logic signed [W-1:0]  pc_y    [N_STEPS+1];
    t_angle               pc_acc  [N_STEPS+1];
    t_spec                pc_spec [N_STEPS+1];

    logic signed [SB-1:0] w_px;
    logic signed [W-1:0]  w_px_w;
    t_spec                w_pspec;

    logic   r_dly_v    [D];
    t_angle r_dly_acc  [D];
    t_spec  r_dly_spec [D];

    t_angle_w w_roll;
    t_angle_w w_pitch;

    logic                      r_out_valid;
    logic signed [ROLL_W-1:0]  r_roll;
    logic signed [PITCH_W-1:0] r_pitch;

    assign w_ce       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (w_ce) begin
            r_v0 <= i_in.valid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_x  <= i_in.accel_x;
            r_y  <= i_in.accel_y;
            r_z  <= i_in.accel_z;
            r_yy <= MW'(r_y * r_y);
            r_zz <= MW'(r_z * r_z);
            r_x1 <= r_x;
        end
    end

    assign w_y0 = W'(r_y);
    assign w_z0 = W'(r_z);

    always_comb begin
        w_base  = '0;
        w_rspec = SP_NONE;
        if (r_z[SB-1]) begin
            w_base = r_y[SB-1] ? -ANG_180 : ANG_180;
        end
        if (r_z == '0) begin
            if (r_y[SB-1]) begin
                w_rspec = SP_NEG90;
            end else if (r_y != '0) begin
                w_rspec = SP_POS90;
            end else begin
                w_rspec = SP_ZERO;
            end
        end
    end

    assign rc_v[0]    = r_v0;
    assign rc_x[0]    = (r_z[SB-1] ? -w_z0 : w_z0) <<< FRAC_IN;
    assign rc_y[0]    = (r_z[SB-1] ? -w_y0 : w_y0) <<< FRAC_IN;
    assign rc_acc[0]  = w_base;
    assign rc_spec[0] = w_rspec;

    for (genvar k = 0; k < N_STEPS; k++) begin : g_roll
        atrp_cordic_cell #(.W(W), .STEP(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_valid (rc_v[k]),
            .i_x     (rc_x[k]),
            .i_y     (rc_y[k]),
            .i_acc   (rc_acc[k]),
            .i_spec  (rc_spec[k]),
            .o_valid (rc_v[k+1]),
            .o_x     (rc_x[k+1]),
            .o_y     (rc_y[k+1]),
            .o_acc   (rc_acc[k+1]),
            .o_spec  (rc_spec[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < D; k++) begin
                r_dly_v[k] <= 1'b0;
            end
        end else if (w_ce) begin
            r_dly_v[0] <= rc_v[N_STEPS];
            for (int k = 1; k < D; k++) begin
                r_dly_v[k] <= r_dly_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_dly_acc[0]  <= rc_acc[N_STEPS];
            r_dly_spec[0] <= rc_spec[N_STEPS];
            for (int k = 1; k < D; k++) begin
                r_dly_acc[k]  <= r_dly_acc[k-1];
                r_dly_spec[k] <= r_dly_spec[k-1];
            end
        end
    end

    assign sq_v[0]    = r_v1;
    assign sq_rad[0]  = r_yy + r_zz;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = r_x1;

    for (genvar k = 0; k < R; k++) begin : g_sqrt
        atrp_sqrt_cell #(.MW(MW), .R(R), .SW(SB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_valid (sq_v[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_v[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    assign w_px   = $signed(sq_side[R]);
    assign w_px_w = W'(w_px);

    always_comb begin
        w_pspec = SP_NONE;
        if (sq_root[R] == '0) begin
            if (w_px[SB-1]) begin
                w_pspec = SP_POS90;
            end else if (w_px != '0) begin
                w_pspec = SP_NEG90;
            end else begin
                w_pspec = SP_ZERO;
            end
        end
    end

    assign pc_v[0]    = sq_v[R];
    assign pc_x[0]    = $signed({{(W-R){1'b0}}, sq_root[R]});
    assign pc_y[0]    = (-w_px_w) <<< FRAC_IN;
    assign pc_acc[0]  = '0;
    assign pc_spec[0] = w_pspec;

    for (genvar k = 0; k < N_STEPS; k++) begin : g_pitch
        atrp_cordic_cell #(.W(W), .STEP(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_valid (pc_v[k]),
            .i_x     (pc_x[k]),
            .i_y     (pc_y[k]),
            .i_acc   (pc_acc[k]),
            .i_spec  (pc_spec[k]),
            .o_valid (pc_v[k+1]),
            .o_x     (pc_x[k+1]),
            .o_y     (pc_y[k+1]),
            .o_acc   (pc_acc[k+1]),
            .o_spec  (pc_spec[k+1])
        );
    end

    assign w_roll  = f_sat(f_round(r_dly_acc[D-1], r_dly_spec[D-1]), ROLL_LIM);
    assign w_pitch = f_sat(f_round(pc_acc[N_STEPS], pc_spec[N_STEPS]), PITCH_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ce) begin
            r_out_valid <= pc_v[N_STEPS] && r_dly_v[D-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_roll  <= w_roll[ROLL_W-1:0];
            r_pitch <= w_pitch[PITCH_W-1:0];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.roll_angle  = r_roll;
    assign o_out.pitch_angle = r_pitch;
endmodule

[src/atrp_checker.sv]
module atrp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [atrp_pkg::ROLL_W-1:0]  i_roll,
    input logic signed [atrp_pkg::PITCH_W-1:0] i_pitch
);
    import atrp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_roll) && $stable(i_pitch))
        else $error("result changed while stalled");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready |-> !i_in_ready) and (!i_out_valid |-> i_in_ready))
        else $error("input ready disagrees with output stall");

    a_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_roll <= 15'sd11520) && (i_roll >= -15'sd11520))
        else $error("roll out of range");

    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pitch <= 14'sd5760) && (i_pitch >= -14'sd5760))
        else $error("pitch out of range");
endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_roll      (o_out.roll_angle),
    .i_pitch     (o_out.pitch_angle)
);
